/* rtl/mvmd_pkg.sv */
// shared constants, types and register codes of the moving-variance motion detector
// no dependencies: used by mvmd_div and moving_variance_motion_detector
`default_nettype none

package mvmd_pkg;

  // window and sample sizing
  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;

  // fixed field and register widths
  localparam int IN_W    = 16;   // input tdata
  localparam int OUT_W   = 32;   // output tdata
  localparam int WL_W    = 7;    // window length register
  localparam int THR_W   = 32;   // threshold register
  localparam int VAR_W   = 30;   // variance field
  localparam int CFG_A_W = 2;    // register index

  // derived widths
  localparam int POS_W  = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + POS_W;
  localparam int SQR_W  = 2 * SAMPLE_BITS;
  localparam int SQ_W   = SQR_W + POS_W;
  localparam int NUM_W  = SQ_W + POS_W;
  localparam int DVS_W  = 2 * CNT_W;
  localparam int PROD_W = SUM_W + SQ_W;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  // reset values of the registers
  localparam logic [WL_W-1:0]  WL_RESET  = WL_W'(50);
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(65536);

  localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

  // register indexes
  localparam logic [CFG_A_W-1:0] REG_WINDOW_LENGTH = CFG_A_W'(0);
  localparam logic [CFG_A_W-1:0] REG_THRESHOLD     = CFG_A_W'(1);

endpackage

`default_nettype wire

/* rtl/mvmd_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module mvmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/mvmd_div.sv */
// iterative restoring divider, one quotient bit per cycle
// depends on mvmd_pkg
`default_nettype none

module mvmd_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [mvmd_pkg::NUM_W-1:0]  dividend_i,
  input  wire logic [mvmd_pkg::DVS_W-1:0]  divisor_i,
  output logic                             done_o,
  output logic      [mvmd_pkg::NUM_W-1:0]  quot_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [mvmd_pkg::DCNT_W-1:0]    cnt_q, cnt_d;
  logic [mvmd_pkg::NUM_W-1:0]     quo_q, quo_d;
  logic [mvmd_pkg::DVS_W-1:0]     rem_q, rem_d;
  logic [mvmd_pkg::DVS_W-1:0]     dvs_q, dvs_d;
  logic [mvmd_pkg::DVS_W:0]       trial;
  logic                           fits;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem_q, quo_q[mvmd_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = mvmd_pkg::DCNT_W'(mvmd_pkg::NUM_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? mvmd_pkg::DVS_W'(trial - {1'b0, dvs_q})
                   : mvmd_pkg::DVS_W'(trial);
      quo_d = {quo_q[mvmd_pkg::NUM_W-2:0], fits};
      cnt_d = cnt_q - mvmd_pkg::DCNT_W'(1);
      if (cnt_q == mvmd_pkg::DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

  // partial remainder never reaches the divisor
  a_rem_below_dvs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && dvs_q != '0) |-> (rem_q < dvs_q))
    else $error("divider remainder not below divisor");

  // completion pulse only once the iteration has stopped
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  // a start loads a full run of steps
  a_start_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> (busy_q && cnt_q == mvmd_pkg::DCNT_W'(mvmd_pkg::NUM_W)))
    else $error("divider start did not load the step count");

endmodule

`default_nettype wire

/* rtl/moving_variance_motion_detector.sv */
// top level of the moving-variance motion detector: sequencer, shared multiplier, sums
// depends on mvmd_pkg, mvmd_ram and mvmd_div
`default_nettype none

// usage
//   input beats (s_axis) carry one unsigned q8.8 sample each; output beats (m_axis)
//   carry the motion flag, the q14.16 window variance and the window-full flag
//   for that sample, exactly one output beat per input beat
//   configuration writes (cfg_we_i, cfg_index_i, cfg_wdata_i) take effect at the
//   clock edge; index 0 sets the window length and clears the window, index 1 sets
//   the threshold; writes are expected only while the block is idle
// timing
//   one sample is worked on at a time; s_axis_tready_o is high only in the idle state
//   before the window is full a beat passes through the old, new, update and final
//   states; with the window full it also passes through the three multiply states,
//   the numerator state and the divider wait, which is set by the 44-step restoring
//   divider that computes (n*sumsq - sum^2) / (n*n) one quotient bit per cycle;
//   the products before it go one per cycle through a single shared multiplier
// reset and stalls
//   reset empties the window, clears the sums and the motion flag and loads the
//   default window length 50 and threshold 1.0; the window memory itself is not cleared
//   the result sits in an output register, so the next sample is accepted while a
//   finished beat still waits; a further result waits in the final state until the
//   output register is free
module moving_variance_motion_detector (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // slave side: [15:0] sample
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [mvmd_pkg::IN_W-1:0]     s_axis_tdata_i,
  // master side: [0] motion, [30:1] variance, [31] window_full
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic      [mvmd_pkg::OUT_W-1:0]    m_axis_tdata_o,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [mvmd_pkg::CFG_A_W-1:0]  cfg_index_i,
  input  wire logic [mvmd_pkg::THR_W-1:0]    cfg_wdata_i
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_OLD  = 10'b00_0000_0010,  // square the evicted sample
    S_NEW  = 10'b00_0000_0100,  // square the new sample
    S_UPD  = 10'b00_0000_1000,  // update sums, window and pointers
    S_MA   = 10'b00_0001_0000,  // n * sumsq
    S_MB   = 10'b00_0010_0000,  // sum * sum
    S_MN   = 10'b00_0100_0000,  // n * n
    S_SUB  = 10'b00_1000_0000,  // numerator, divider start
    S_DIV  = 10'b01_0000_0000,  // wait for the quotient
    S_FIN  = 10'b10_0000_0000   // flag update and output load
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [mvmd_pkg::WL_W-1:0]   wl_q, wl_d;
  logic [mvmd_pkg::THR_W-1:0]  thr_q, thr_d;

  // window bookkeeping
  logic [mvmd_pkg::POS_W-1:0]  pos_q, pos_d;       // next write position
  logic [mvmd_pkg::CNT_W-1:0]  fill_q, fill_d;
  logic [mvmd_pkg::SUM_W-1:0]  sum_q, sum_d;
  logic [mvmd_pkg::SQ_W-1:0]   sq_q, sq_d;
  logic                        motion_q, motion_d;

  // per-beat working registers
  logic [mvmd_pkg::SAMPLE_BITS-1:0] smp_q, smp_d;
  logic [mvmd_pkg::SAMPLE_BITS-1:0] old_q, old_d;
  logic [mvmd_pkg::SQR_W-1:0]       oldsq_q, oldsq_d;
  logic [mvmd_pkg::POS_W-1:0]       wpos_q, wpos_d;    // position of this beat
  logic                             evict_q, evict_d;
  logic                             full_q, full_d;
  logic [mvmd_pkg::NUM_W-1:0]       a_q, a_d;
  logic [mvmd_pkg::NUM_W-1:0]       b_q, b_d;
  logic [mvmd_pkg::VAR_W-1:0]       var_q, var_d;

  // output register
  logic                             out_valid_q, out_valid_d;
  logic [mvmd_pkg::OUT_W-1:0]       out_data_q, out_data_d;

  // shared multiplier
  logic [mvmd_pkg::SUM_W-1:0]  mul_a;
  logic [mvmd_pkg::SQ_W-1:0]   mul_b;
  logic [mvmd_pkg::PROD_W-1:0] prod_q;

  // window memory
  logic                             ram_re, ram_we;
  logic [mvmd_pkg::SAMPLE_BITS-1:0] ram_rdata;

  // divider
  logic                        div_start;
  logic [mvmd_pkg::NUM_W-1:0]  div_num;
  logic                        div_done;
  logic [mvmd_pkg::NUM_W-1:0]  div_quot;

  logic [mvmd_pkg::CNT_W-1:0]  n_eff;
  logic [mvmd_pkg::POS_W-1:0]  pos_eff;
  logic [mvmd_pkg::CNT_W-1:0]  pos_inc;
  logic [mvmd_pkg::CNT_W-1:0]  fill_new;
  logic [mvmd_pkg::SAMPLE_BITS-1:0] old_smp;
  logic                        in_beat, out_free;
  logic [mvmd_pkg::THR_W-1:0]  var_ext;
  logic                        flag_new;

  // length zero acts as one, lengths beyond the window act as the full window
  always_comb begin
    if (wl_q == '0) begin
      n_eff = mvmd_pkg::CNT_W'(1);
    end else if (32'(wl_q) > mvmd_pkg::MAX_WINDOW) begin
      n_eff = mvmd_pkg::CNT_W'(mvmd_pkg::MAX_WINDOW);
    end else begin
      n_eff = mvmd_pkg::CNT_W'(wl_q);
    end
  end

  assign pos_eff  = (mvmd_pkg::CNT_W'(pos_q) >= n_eff) ? '0 : pos_q;
  assign pos_inc  = mvmd_pkg::CNT_W'(wpos_q) + mvmd_pkg::CNT_W'(1);
  assign fill_new = evict_q ? n_eff : fill_q + mvmd_pkg::CNT_W'(1);
  assign old_smp  = evict_q ? ram_rdata : '0;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // hysteresis: set above, clear below, hold on equality
  assign var_ext  = mvmd_pkg::THR_W'(var_q);
  assign flag_new = motion_q ? !(var_ext < thr_q) : (var_ext > thr_q);

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_OLD: begin
        mul_a = mvmd_pkg::SUM_W'(old_smp);
        mul_b = mvmd_pkg::SQ_W'(old_smp);
      end
      S_NEW: begin
        mul_a = mvmd_pkg::SUM_W'(smp_q);
        mul_b = mvmd_pkg::SQ_W'(smp_q);
      end
      S_MA: begin
        mul_a = mvmd_pkg::SUM_W'(n_eff);
        mul_b = sq_q;
      end
      S_MB: begin
        mul_a = sum_q;
        mul_b = mvmd_pkg::SQ_W'(sum_q);
      end
      S_MN: begin
        mul_a = mvmd_pkg::SUM_W'(n_eff);
        mul_b = mvmd_pkg::SQ_W'(n_eff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  assign ram_re    = in_beat;
  assign ram_we    = (state_q == S_UPD);
  assign div_start = (state_q == S_SUB);
  assign div_num   = (a_q >= b_q) ? a_q - b_q : '0;

  // sequencer and datapath
  always_comb begin
    state_d     = state_q;
    wl_d        = wl_q;
    thr_d       = thr_q;
    pos_d       = pos_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    sq_d        = sq_q;
    motion_d    = motion_q;
    smp_d       = smp_q;
    old_d       = old_q;
    oldsq_d     = oldsq_q;
    wpos_d      = wpos_q;
    evict_d     = evict_q;
    full_d      = full_q;
    a_d         = a_q;
    b_d         = b_q;
    var_d       = var_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          smp_d   = mvmd_pkg::SAMPLE_BITS'(s_axis_tdata_i);
          wpos_d  = pos_eff;
          evict_d = fill_q >= n_eff;
          state_d = S_OLD;
        end
      end
      S_OLD: begin
        old_d   = old_smp;
        state_d = S_NEW;
      end
      S_NEW: begin
        oldsq_d = mvmd_pkg::SQR_W'(prod_q);
        state_d = S_UPD;
      end
      S_UPD: begin
        sum_d  = sum_q - mvmd_pkg::SUM_W'(old_q) + mvmd_pkg::SUM_W'(smp_q);
        sq_d   = sq_q - mvmd_pkg::SQ_W'(oldsq_q) + mvmd_pkg::SQ_W'(prod_q);
        fill_d = fill_new;
        pos_d  = (pos_inc >= n_eff) ? '0 : mvmd_pkg::POS_W'(pos_inc);
        full_d = fill_new >= n_eff;
        if (fill_new >= n_eff) begin
          state_d = S_MA;
        end else begin
          var_d   = '0;
          state_d = S_FIN;
        end
      end
      S_MA: begin
        state_d = S_MB;
      end
      S_MB: begin
        a_d     = mvmd_pkg::NUM_W'(prod_q);
        state_d = S_MN;
      end
      S_MN: begin
        b_d     = mvmd_pkg::NUM_W'(prod_q);
        state_d = S_SUB;
      end
      S_SUB: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          // saturate quotients that do not fit the variance field
          if ((div_quot >> mvmd_pkg::VAR_W) != '0) begin
            var_d = mvmd_pkg::VAR_MAX;
          end else begin
            var_d = mvmd_pkg::VAR_W'(div_quot);
          end
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          motion_d    = flag_new;
          out_valid_d = 1'b1;
          out_data_d  = {full_q, var_q, flag_new};
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // register writes
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        mvmd_pkg::REG_WINDOW_LENGTH: begin
          wl_d   = mvmd_pkg::WL_W'(cfg_wdata_i);
          pos_d  = '0;
          fill_d = '0;
          sum_d  = '0;
          sq_d   = '0;
        end
        mvmd_pkg::REG_THRESHOLD: begin
          thr_d = cfg_wdata_i;
        end
        default: begin
          thr_d = thr_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wl_q        <= mvmd_pkg::WL_RESET;
      thr_q       <= mvmd_pkg::THR_RESET;
      pos_q       <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      motion_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wl_q        <= wl_d;
      thr_q       <= thr_d;
      pos_q       <= pos_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      sq_q        <= sq_d;
      motion_q    <= motion_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q      <= smp_d;
    old_q      <= old_d;
    oldsq_q    <= oldsq_d;
    wpos_q     <= wpos_d;
    evict_q    <= evict_d;
    full_q     <= full_d;
    a_q        <= a_d;
    b_q        <= b_d;
    var_q      <= var_d;
    out_data_q <= out_data_d;
  end

  mvmd_ram #(
    .WIDTH (mvmd_pkg::SAMPLE_BITS),
    .DEPTH (mvmd_pkg::MAX_WINDOW)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wpos_q),
    .wdata_i (smp_q),
    .re_i    (ram_re),
    .raddr_i (pos_eff),
    .rdata_o (ram_rdata)
  );

  mvmd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (mvmd_pkg::DVS_W'(prod_q)),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // fill level never exceeds the effective window length
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= n_eff)
    else $error("fill count above window length");

  // write pointer stays inside the window
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mvmd_pkg::CNT_W'(pos_q) < n_eff)
    else $error("write position outside window");

  // the quotient only arrives while the sequencer waits for it
  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the wait state");

endmodule

`default_nettype wire
